FILE: src/kcm_pkg.sv
// Shared constants, handshake structs and the symbol table of the charset mapper.
`default_nettype none
package kcm_pkg;

	localparam int BYTE_W       = 8;
	localparam int CHAR_W       = 7;
	localparam int LEN_W        = 6;
	localparam int DIV_W        = 7;
	localparam int DIV_STEPS    = BYTE_W;
	localparam int DIV_CNT_W    = $clog2(DIV_STEPS + 1);
	localparam int SYMBOL_COUNT = 76;
	localparam int MAX_RESULTS  = 32;

	typedef struct packed {
		logic              start;
		logic [BYTE_W-1:0] dividend;
		logic [DIV_W-1:0]  divisor;
	} div_req_t;

	typedef struct packed {
		logic             busy;
		logic             done;
		logic [DIV_W-1:0] rem;
	} div_rsp_t;

	// Maps a symbol index 0..75 onto its ASCII code.
	function automatic logic [CHAR_W-1:0] symbol_char(input logic [DIV_W-1:0] idx);
		logic [CHAR_W-1:0] code;
		code = 7'd65;
		if (idx < 7'd26) begin
			code = 7'd65 + idx;
		end else if (idx < 7'd52) begin
			code = 7'd97 + (idx - 7'd26);
		end else if (idx < 7'd62) begin
			code = 7'd48 + (idx - 7'd52);
		end else begin
			unique case (idx)
				7'd62:   code = 7'd33;  // !
				7'd63:   code = 7'd64;  // @
				7'd64:   code = 7'd35;  // #
				7'd65:   code = 7'd36;  // $
				7'd66:   code = 7'd37;  // %
				7'd67:   code = 7'd94;  // ^
				7'd68:   code = 7'd38;  // &
				7'd69:   code = 7'd42;  // *
				7'd70:   code = 7'd40;  // (
				7'd71:   code = 7'd41;  // )
				7'd72:   code = 7'd45;  // -
				7'd73:   code = 7'd95;  // _
				7'd74:   code = 7'd61;  // =
				7'd75:   code = 7'd43;  // +
				default: code = 7'd65;
			endcase
		end
		return code;
	endfunction

endpackage
`default_nettype wire

FILE: src/kcm_if.sv
// Valid/ready channel interfaces for digest bytes in and characters out.
`default_nettype none
interface kcm_in_if;
	logic                      valid;
	logic                      ready;
	logic [kcm_pkg::BYTE_W-1:0] digest_byte;

	modport source (output valid, output digest_byte, input ready);
	modport sink (input valid, input digest_byte, output ready);
endinterface

interface kcm_out_if;
	logic                      valid;
	logic                      ready;
	logic [kcm_pkg::CHAR_W-1:0] char_code;
	logic                      last_char;

	modport source (output valid, output char_code, output last_char, input ready);
	modport sink (input valid, input char_code, input last_char, output ready);
endinterface
`default_nettype wire

FILE: src/keyed_shuffle_charset_mapper.sv
// Top level: digest store, keyed shuffle sequencer and character emission.
//
//   channel    | dir | handshake            | word
//   digest     | in  | valid/ready          | digest_byte[7:0]
//   chars      | out | valid/ready          | char_code[6:0], last_char
//   cfg        | in  | cfg_wen, no back-off | cfg_wdata[5:0] (output_length)
//
// Digest bytes are taken only while the block is loading. After the last byte the block
// runs a permutation init sweep, then DIGEST_BYTES-1 swaps and n characters, n the
// emitted length; each swap and each character passes through the shared modulo unit
// plus accesses to the digest and permutation stores.
// Reset clears the sequencer and loads output_length with 32; stores hold no reset.
// A stalled character holds the sequencer until the word is taken.
`default_nettype none
module keyed_shuffle_charset_mapper #(
	parameter int DIGEST_BYTES = 32
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       cfg_wen,
	input  wire logic [kcm_pkg::LEN_W-1:0]  cfg_wdata,
	kcm_in_if.sink                          digest,
	kcm_out_if.source                       chars
);

	localparam int IW = $clog2(DIGEST_BYTES);
	localparam logic [kcm_pkg::LEN_W-1:0] N_CAP = kcm_pkg::LEN_W'(
		(DIGEST_BYTES < kcm_pkg::MAX_RESULTS) ? DIGEST_BYTES : kcm_pkg::MAX_RESULTS);

	localparam logic [3:0] S_LOAD    = 4'd0;
	localparam logic [3:0] S_INIT    = 4'd1;
	localparam logic [3:0] S_SW_RD   = 4'd2;
	localparam logic [3:0] S_SW_GO   = 4'd3;
	localparam logic [3:0] S_SW_WAIT = 4'd4;
	localparam logic [3:0] S_SW_PRD  = 4'd5;
	localparam logic [3:0] S_SW_WA   = 4'd6;
	localparam logic [3:0] S_SW_WB   = 4'd7;
	localparam logic [3:0] S_EM_PRD  = 4'd8;
	localparam logic [3:0] S_EM_DRD  = 4'd9;
	localparam logic [3:0] S_EM_GO   = 4'd10;
	localparam logic [3:0] S_EM_WAIT = 4'd11;
	localparam logic [3:0] S_EM_OUT  = 4'd12;

	logic [3:0]                    state_q;
	logic [IW-1:0]                 cnt_q;
	logic [IW-1:0]                 i_q;
	logic [IW-1:0]                 partner_q;
	logic [kcm_pkg::LEN_W-1:0]     k_q;
	logic [kcm_pkg::LEN_W-1:0]     n_q;
	logic [kcm_pkg::LEN_W-1:0]     cfg_q;
	logic                          out_valid_q;
	logic [kcm_pkg::CHAR_W-1:0]    char_q;
	logic                          last_q;

	logic [kcm_pkg::BYTE_W-1:0]    digest_mem [DIGEST_BYTES];
	logic [IW-1:0]                 perm_mem [DIGEST_BYTES];
	logic [kcm_pkg::BYTE_W-1:0]    d_rd_q;
	logic [IW-1:0]                 prd_a_q;
	logic [IW-1:0]                 prd_b_q;

	logic                          d_we;
	logic                          d_re;
	logic [IW-1:0]                 d_raddr;
	logic                          p_we;
	logic [IW-1:0]                 p_waddr;
	logic [IW-1:0]                 p_wdata;
	logic                          p_re;
	logic [IW-1:0]                 p_raddr_a;
	logic [kcm_pkg::LEN_W-1:0]     n_next;

	kcm_pkg::div_req_t             div_req;
	kcm_pkg::div_rsp_t             div_rsp;

	kcm_modu u_modu (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	assign digest.ready    = (state_q == S_LOAD);
	assign chars.valid     = out_valid_q;
	assign chars.char_code = char_q;
	assign chars.last_char = last_q;

	assign n_next = (cfg_q > N_CAP) ? N_CAP : cfg_q;

	always_comb begin
		d_we      = (state_q == S_LOAD) && digest.valid;
		d_re      = (state_q == S_SW_RD) || (state_q == S_EM_DRD);
		d_raddr   = (state_q == S_SW_RD) ? i_q : prd_a_q;
		p_re      = (state_q == S_SW_PRD) || (state_q == S_EM_PRD);
		p_raddr_a = (state_q == S_SW_PRD) ? i_q : k_q[IW-1:0];
		p_we      = (state_q == S_INIT) || (state_q == S_SW_WA) || (state_q == S_SW_WB);
		p_waddr   = (state_q == S_SW_WB) ? partner_q : i_q;
		p_wdata   = i_q;
		if (state_q == S_SW_WA) begin
			p_wdata = prd_b_q;
		end else if (state_q == S_SW_WB) begin
			p_wdata = prd_a_q;
		end
		div_req.start    = (state_q == S_SW_GO) || (state_q == S_EM_GO);
		div_req.dividend = d_rd_q;
		div_req.divisor  = (state_q == S_EM_GO) ? kcm_pkg::DIV_W'(kcm_pkg::SYMBOL_COUNT)
		                                         : kcm_pkg::DIV_W'(i_q) + 7'd1;
	end

	always_ff @(posedge clk) begin
		if (d_we) begin
			digest_mem[cnt_q] <= digest.digest_byte;
		end
		if (d_re) begin
			d_rd_q <= digest_mem[d_raddr];
		end
	end

	always_ff @(posedge clk) begin
		if (p_we) begin
			perm_mem[p_waddr] <= p_wdata;
		end
		if (p_re) begin
			prd_a_q <= perm_mem[p_raddr_a];
			prd_b_q <= perm_mem[partner_q];
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_SW_WAIT && div_rsp.done) begin
			partner_q <= div_rsp.rem[IW-1:0];
		end
		if (state_q == S_EM_WAIT && div_rsp.done) begin
			char_q <= kcm_pkg::symbol_char(div_rsp.rem);
			last_q <= ((k_q + 1'b1) == n_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= kcm_pkg::LEN_W'(32);
		end else if (cfg_wen) begin
			cfg_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_LOAD;
			cnt_q       <= '0;
			i_q         <= '0;
			k_q         <= '0;
			n_q         <= '0;
			out_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				S_LOAD: begin
					if (digest.valid) begin
						if (cnt_q == IW'(DIGEST_BYTES - 1)) begin
							cnt_q   <= '0;
							i_q     <= '0;
							state_q <= S_INIT;
						end else begin
							cnt_q <= cnt_q + 1'b1;
						end
					end
				end
				// The identity sweep leaves i_q at the top index, where the shuffle starts.
				S_INIT: begin
					if (i_q == IW'(DIGEST_BYTES - 1)) begin
						state_q <= S_SW_RD;
					end else begin
						i_q <= i_q + 1'b1;
					end
				end
				S_SW_RD:   state_q <= S_SW_GO;
				S_SW_GO:   state_q <= S_SW_WAIT;
				S_SW_WAIT: begin
					if (div_rsp.done) begin
						state_q <= S_SW_PRD;
					end
				end
				S_SW_PRD:  state_q <= S_SW_WA;
				S_SW_WA:   state_q <= S_SW_WB;
				S_SW_WB: begin
					if (i_q == IW'(1)) begin
						k_q     <= '0;
						n_q     <= n_next;
						state_q <= (n_next == '0) ? S_LOAD : S_EM_PRD;
					end else begin
						i_q     <= i_q - 1'b1;
						state_q <= S_SW_RD;
					end
				end
				S_EM_PRD:  state_q <= S_EM_DRD;
				S_EM_DRD:  state_q <= S_EM_GO;
				S_EM_GO:   state_q <= S_EM_WAIT;
				S_EM_WAIT: begin
					if (div_rsp.done) begin
						out_valid_q <= 1'b1;
						state_q     <= S_EM_OUT;
					end
				end
				S_EM_OUT: begin
					if (chars.ready) begin
						out_valid_q <= 1'b0;
						if (last_q) begin
							state_q <= S_LOAD;
						end else begin
							k_q     <= k_q + 1'b1;
							state_q <= S_EM_PRD;
						end
					end
				end
				default: state_q <= S_LOAD;
			endcase
		end
	end

	a_valid_only_in_emit: assert property (@(posedge clk) disable iff (!arst_n)
		chars.valid |-> (state_q == S_EM_OUT))
		else $error("character word valid outside the emit state");

	a_no_load_while_emitting: assert property (@(posedge clk) disable iff (!arst_n)
		chars.valid |-> !digest.ready)
		else $error("digest taken while a character is pending");

	a_div_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		div_req.start |-> !div_rsp.busy)
		else $error("modulo unit started while busy");

	a_last_returns_to_load: assert property (@(posedge clk) disable iff (!arst_n)
		(chars.valid && chars.ready && chars.last_char) |=> (state_q == S_LOAD))
		else $error("sequencer did not return to loading after the last character");

endmodule
`default_nettype wire

FILE: src/kcm_modu.sv
// Shared restoring modulo unit: one dividend bit per cycle.
`default_nettype none
module kcm_modu (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire kcm_pkg::div_req_t req,
	output kcm_pkg::div_rsp_t      rsp
);

	logic [kcm_pkg::BYTE_W-1:0]    dvd_q;
	logic [kcm_pkg::DIV_W-1:0]     dvs_q;
	logic [kcm_pkg::DIV_W-1:0]     rem_q;
	logic [kcm_pkg::DIV_CNT_W-1:0] cnt_q;
	logic                          done_q;
	logic [kcm_pkg::DIV_W:0]       rem_sh;
	logic [kcm_pkg::DIV_W-1:0]     rem_nx;

	// The partial remainder stays below the divisor, so the shifted value fits one extra bit.
	always_comb begin
		rem_sh = {rem_q, dvd_q[kcm_pkg::BYTE_W-1]};
		if (rem_sh >= {1'b0, dvs_q}) begin
			rem_nx = kcm_pkg::DIV_W'(rem_sh - {1'b0, dvs_q});
		end else begin
			rem_nx = rem_sh[kcm_pkg::DIV_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else if (req.start) begin
			cnt_q  <= kcm_pkg::DIV_CNT_W'(kcm_pkg::DIV_STEPS);
			done_q <= 1'b0;
		end else if (cnt_q != '0) begin
			cnt_q  <= cnt_q - 1'b1;
			done_q <= (cnt_q == kcm_pkg::DIV_CNT_W'(1));
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			dvd_q <= req.dividend;
			dvs_q <= req.divisor;
			rem_q <= '0;
		end else if (cnt_q != '0) begin
			dvd_q <= {dvd_q[kcm_pkg::BYTE_W-2:0], 1'b0};
			rem_q <= rem_nx;
		end
	end

	assign rsp.busy = (cnt_q != '0);
	assign rsp.done = done_q;
	assign rsp.rem  = rem_q;

endmodule
`default_nettype wire

FILE: bench/keyed_shuffle_charset_mapper_tb.sv
// Self-checking testbench for the keyed shuffle charset mapper: directed digests, then random ones.
`default_nettype none
module keyed_shuffle_charset_mapper_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int DIGEST_BYTES = 32;
	localparam int RANDOM_ITEMS = 178;
	// Wait for the block to finish a digest before the length register is written.
	localparam int DRAIN_CYCLES = 1200;
	localparam int IDLE_LIMIT   = 20000;

	typedef enum logic [1:0] {
		FILL_FLAT,
		FILL_RAMP,
		FILL_DOWN,
		FILL_ALT
	} fill_e;

	typedef struct packed {
		logic [kcm_pkg::CHAR_W-1:0] code;
		logic                       last;
	} char_word_t;

	typedef struct {
		bit                         load_len;
		logic [kcm_pkg::LEN_W-1:0]  len;
		fill_e                      fill;
		logic [kcm_pkg::BYTE_W-1:0] seed;
		bit                         typed;
		logic [kcm_pkg::CHAR_W-1:0] code;
		bit                         calm;
	} digest_case_t;

	// Each row is one whole digest. Rows with typed set carry the character that every
	// position must show, since a flat digest maps every slot to the same symbol.
	digest_case_t plan [6] = '{
		'{1'b0, 6'd32, FILL_FLAT, 8'h00, 1'b1, 7'd65, 1'b0},
		'{1'b1, 6'd1,  FILL_FLAT, 8'hFF, 1'b1, 7'd98, 1'b1},
		'{1'b1, 6'd0,  FILL_RAMP, 8'h00, 1'b0, 7'd0,  1'b0},
		'{1'b1, 6'd63, FILL_FLAT, 8'd75, 1'b1, 7'd43, 1'b0},
		'{1'b1, 6'd33, FILL_DOWN, 8'hFF, 1'b0, 7'd0,  1'b1},
		'{1'b1, 6'd16, FILL_ALT,  8'h5A, 1'b0, 7'd0,  1'b0}
	};

	logic [kcm_pkg::LEN_W-1:0]  len_picks [8] = '{6'd0, 6'd1, 6'd16, 6'd24, 6'd31, 6'd32,
		6'd33, 6'd63};
	logic [kcm_pkg::BYTE_W-1:0] edge_bytes [14] = '{8'd0, 8'd25, 8'd26, 8'd51, 8'd52, 8'd61,
		8'd62, 8'd75, 8'd76, 8'd151, 8'd152, 8'd227, 8'd228, 8'd255};

	string symbols = "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789!@#$%^&*()-_=+";

	logic clk;
	logic arst_n;
	logic cfg_wen;
	logic [kcm_pkg::LEN_W-1:0] cfg_wdata;

	kcm_in_if  digest_ch ();
	kcm_out_if chars_ch ();

	keyed_shuffle_charset_mapper #(
		.DIGEST_BYTES(DIGEST_BYTES)
	) u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_wen  (cfg_wen),
		.cfg_wdata(cfg_wdata),
		.digest   (digest_ch),
		.chars    (chars_ch)
	);

	logic [kcm_pkg::BYTE_W-1:0] key_bytes [DIGEST_BYTES];
	int                         key_fill = 0;
	logic [kcm_pkg::LEN_W-1:0]  char_len = 6'd32;
	char_word_t                 pending_chars [$];
	int unsigned                mismatches = 0;
	int unsigned                quiet_cycles = 0;
	bit                         steady = 1'b0;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Store one key byte; once a whole digest is in, shuffle it and queue the characters it must produce.
	task automatic absorb_key_byte(input logic [kcm_pkg::BYTE_W-1:0] b, input bit typed,
			input logic [kcm_pkg::CHAR_W-1:0] typed_code);
		int order [DIGEST_BYTES];
		int i, partner, held, n, sym;
		char_word_t w;
		key_bytes[key_fill] = b;
		key_fill++;
		if (key_fill == DIGEST_BYTES) begin
			key_fill = 0;
			for (i = 0; i < DIGEST_BYTES; i++) order[i] = i;
			for (i = DIGEST_BYTES - 1; i > 0; i--) begin
				partner = int'(key_bytes[i]) % (i + 1);
				held = order[i];
				order[i] = order[partner];
				order[partner] = held;
			end
			n = (int'(char_len) > DIGEST_BYTES) ? DIGEST_BYTES : int'(char_len);
			if (n > kcm_pkg::MAX_RESULTS) n = kcm_pkg::MAX_RESULTS;
			for (i = 0; i < n; i++) begin
				sym = int'(key_bytes[order[i]]) % kcm_pkg::SYMBOL_COUNT;
				w.code = typed ? typed_code : kcm_pkg::CHAR_W'(symbols[sym]);
				w.last = (i == n - 1);
				pending_chars.push_back(w);
			end
		end
	endtask

	// Called at a rising edge; returns at the edge that takes the word.
	task automatic feed_byte(input logic [kcm_pkg::BYTE_W-1:0] b, input bit typed,
			input logic [kcm_pkg::CHAR_W-1:0] typed_code);
		bit taken;
		while (!steady && $urandom_range(99) < 27) begin
			digest_ch.valid <= 1'b0;
			@(posedge clk);
		end
		digest_ch.valid <= 1'b1;
		digest_ch.digest_byte <= b;
		taken = 1'b0;
		while (!taken) begin
			@(negedge clk);
			taken = digest_ch.ready;
			@(posedge clk);
		end
		absorb_key_byte(b, typed, typed_code);
	endtask

	// The register is only written once the block has drained and gone quiet.
	task automatic set_char_len(input logic [kcm_pkg::LEN_W-1:0] len);
		digest_ch.valid <= 1'b0;
		while (pending_chars.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		cfg_wen <= 1'b1;
		cfg_wdata <= len;
		@(posedge clk);
		cfg_wen <= 1'b0;
		char_len = len;
	endtask

	initial begin
		chars_ch.ready = 1'b0;
		forever begin
			@(posedge clk);
			chars_ch.ready <= steady || ($urandom_range(99) >= 27);
		end
	end

	// Both handshakes are sampled at the falling edge ahead of the rising edge that completes them.
	always @(negedge clk) begin : check_chars
		char_word_t want;
		if (arst_n && chars_ch.valid && chars_ch.ready) begin
			if (pending_chars.size() == 0) begin
				$error("unexpected word: char_code %0d last_char %0b",
					chars_ch.char_code, chars_ch.last_char);
				mismatches++;
			end else begin
				want = pending_chars.pop_front();
				if (chars_ch.char_code !== want.code) begin
					$error("char_code: expected %0d, got %0d", want.code, chars_ch.char_code);
					mismatches++;
				end
				if (chars_ch.last_char !== want.last) begin
					$error("last_char: expected %0b, got %0b", want.last, chars_ch.last_char);
					mismatches++;
				end
			end
		end
	end

	always @(negedge clk) begin
		if ((digest_ch.valid && digest_ch.ready) || (chars_ch.valid && chars_ch.ready)) begin
			quiet_cycles = 0;
		end else begin
			quiet_cycles++;
		end
		if (quiet_cycles >= IDLE_LIMIT) begin
			$display("keyed_shuffle_charset_mapper_tb: errors");
			$finish;
		end
	end

	initial begin
		digest_case_t row;
		logic [kcm_pkg::BYTE_W-1:0] b;
		int r, k, span, sent, phase;
		logic [kcm_pkg::LEN_W-1:0] len;

		arst_n = 1'b0;
		cfg_wen = 1'b0;
		cfg_wdata = '0;
		digest_ch.valid = 1'b0;
		digest_ch.digest_byte = '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (r = 0; r < 6; r++) begin
			row = plan[r];
			if (row.load_len) set_char_len(row.len);
			steady = row.calm;
			for (k = 0; k < DIGEST_BYTES; k++) begin
				case (row.fill)
					FILL_FLAT: b = row.seed;
					FILL_RAMP: b = row.seed + kcm_pkg::BYTE_W'(k);
					FILL_DOWN: b = row.seed - kcm_pkg::BYTE_W'(k);
					default:   b = k[0] ? row.seed : ~row.seed;
				endcase
				feed_byte(b, row.typed, row.code);
			end
		end

		// Phases rarely end on a digest boundary, so most length changes land mid-load.
		sent = 0;
		phase = 0;
		while (sent < RANDOM_ITEMS) begin
			if ($urandom_range(1) == 0) begin
				len = len_picks[$urandom_range(7)];
			end else begin
				len = kcm_pkg::LEN_W'($urandom_range(63));
			end
			set_char_len(len);
			steady = (phase == 2);
			span = $urandom_range(12, 70);
			for (k = 0; k < span && sent < RANDOM_ITEMS; k++) begin
				if ($urandom_range(3) == 0) begin
					b = edge_bytes[$urandom_range(13)];
				end else begin
					b = kcm_pkg::BYTE_W'($urandom_range(255));
				end
				feed_byte(b, 1'b0, '0);
				sent++;
			end
			phase++;
		end

		digest_ch.valid <= 1'b0;
		steady = 1'b0;
		while (pending_chars.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0) begin
			$display("keyed_shuffle_charset_mapper_tb: clean");
		end else begin
			$display("keyed_shuffle_charset_mapper_tb: errors");
		end
		$finish;
	end

endmodule
`default_nettype wire

FILE: filelist.f
src/kcm_pkg.sv
src/kcm_if.sv
src/kcm_modu.sv
src/keyed_shuffle_charset_mapper.sv
bench/keyed_shuffle_charset_mapper_tb.sv
